@@ rtl/gtr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_pkg
// Shared constants and tables of the Gaussian tuning-rate unit.
// ----------------------------------------------------------------------------
package gtr_pkg;

  localparam int unsigned EXP_TABLE_BITS_DEF = 6;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [15:0] SIGMA_RESET = 16'd256;
  localparam logic [15:0] PEAK_RESET  = 16'd256;
  localparam logic [31:0] INV_RESET   = 32'h0080_0000;
  localparam logic [16:0] LOG2E_Q16   = 17'd94548;
  localparam logic [15:0] RATE_MAX    = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_SIGMA   = 2'd0,
    REG_PEAK    = 2'd1,
    REG_ONE_DIM = 2'd2
  } reg_idx_t;

  // 2^(-2^-k) in Q.30.
  function automatic logic [29:0] half_pow_factor(input int unsigned k);
    logic [29:0] f;
    case (k)
      1:       f = 30'd759250125;
      2:       f = 30'd902905651;
      3:       f = 30'd984625594;
      4:       f = 30'd1028218693;
      5:       f = 30'd1050733752;
      6:       f = 30'd1062175491;
      7:       f = 30'd1067943025;
      8:       f = 30'd1070838466;
      9:       f = 30'd1072289173;
      10:      f = 30'd1073015252;
      default: f = 30'd0;
    endcase
    return f;
  endfunction

endpackage

@@ rtl/gtr_inv_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtr_inv_div
// Derives 1/(2*sigma^2) in Q8.24 by bit-serial restoring division.
// ----------------------------------------------------------------------------
module gtr_inv_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] sigma,
  output logic        busy,
  output logic [31:0] inv_scale
);

  typedef enum logic [1:0] {
    DIV_IDLE = 2'b01,
    DIV_RUN  = 2'b10
  } div_state_t;

  div_state_t  state_r;
  logic [31:0] sq_r;
  logic [31:0] rem_r;
  logic [39:0] q_r;
  logic [5:0]  cnt_r;
  logic [31:0] inv_r;

  logic [32:0] rem_sh;
  logic        ge;
  logic [32:0] diff;
  logic [31:0] rem_nxt;
  logic [39:0] q_nxt;

  always_comb begin
    rem_sh  = {rem_r, (cnt_r == 6'd39)};
    ge      = rem_sh >= {1'b0, sq_r};
    diff    = rem_sh - {1'b0, sq_r};
    rem_nxt = ge ? diff[31:0] : rem_sh[31:0];
    q_nxt   = {q_r[38:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      inv_r   <= gtr_pkg::INV_RESET;
      cnt_r   <= 6'd0;
    end else begin
      case (state_r)
        DIV_IDLE: begin
          if (start) begin
            state_r <= DIV_RUN;
            cnt_r   <= 6'd39;
          end
        end
        DIV_RUN: begin
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            state_r <= DIV_IDLE;
            inv_r   <= (|q_nxt[39:32]) ? 32'hFFFF_FFFF : q_nxt[31:0];
          end
        end
        default: state_r <= DIV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == DIV_IDLE) begin
      sq_r  <= 32'(sigma) * 32'(sigma);
      rem_r <= 32'd0;
      q_r   <= 40'd0;
    end else begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign busy      = (state_r == DIV_RUN);
  assign inv_scale = inv_r;

endmodule

@@ rtl/gaussian_tuning_rate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_tuning_rate
// Firing rate of a Gaussian tuning curve for a stream of stimulus-neuron pairs.
// ----------------------------------------------------------------------------
// Each input item carries a stimulus point, a preferred point and a batch-end
// flag. Each item gives exactly one result item with the rate and the flag.
// Items are taken with in_valid/in_stall and delivered with out_valid/
// out_stall. The pipeline has 8 + EXP_TABLE_BITS register stages, and one
// item is accepted per cycle while in_stall is low. Each stage holds its
// item while the stage after it is full and stalled, so empty stages still
// fill while a result waits.
// Registers are written over the APB port. A write of sigma starts a
// bit-serial division that derives the exponent scale; input is stalled
// during it. Reset clears the pipeline and restores sigma and peak_rate to
// 1.0, two-dimensional mode and the matching scale at once.
// ----------------------------------------------------------------------------
module gaussian_tuning_rate #(
  parameter int unsigned EXP_TABLE_BITS = gtr_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          in_stim_x,
  input  logic signed [15:0]          in_stim_y,
  input  logic signed [15:0]          in_pref_x,
  input  logic signed [15:0]          in_pref_y,
  input  logic                        in_batch_end,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [15:0]                 out_rate,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gtr_pkg::AddrW-1:0]   paddr,
  input  logic [gtr_pkg::DataW-1:0]   pwdata,
  output logic [gtr_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  localparam int unsigned T   = EXP_TABLE_BITS;
  localparam int unsigned NST = 8 + T;
  localparam int unsigned SY  = 5;
  localparam int unsigned SP  = 6 + T;
  localparam int unsigned SO  = 7 + T;

  logic [15:0] sigma_r;
  logic [15:0] peak_r;
  logic        one_dim_r;
  logic        wr_en;
  logic [1:0]  wr_idx;
  logic        div_busy;
  logic [31:0] inv_scale;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r   <= gtr_pkg::SIGMA_RESET;
      peak_r    <= gtr_pkg::PEAK_RESET;
      one_dim_r <= 1'b0;
    end else if (wr_en) begin
      case (wr_idx)
        gtr_pkg::REG_SIGMA:   sigma_r   <= pwdata[15:0];
        gtr_pkg::REG_PEAK:    peak_r    <= pwdata[15:0];
        gtr_pkg::REG_ONE_DIM: one_dim_r <= pwdata[0];
        default:              ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      gtr_pkg::REG_SIGMA:   prdata = {16'd0, sigma_r};
      gtr_pkg::REG_PEAK:    prdata = {16'd0, peak_r};
      gtr_pkg::REG_ONE_DIM: prdata = {31'd0, one_dim_r};
      default:              prdata = '0;
    endcase
  end

  gtr_inv_div u_inv_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (wr_en && (wr_idx == gtr_pkg::REG_SIGMA)),
    .sigma     (pwdata[15:0]),
    .busy      (div_busy),
    .inv_scale (inv_scale)
  );

  // Pipeline flow control.
  logic [NST-1:0] v_r;
  logic [NST:0]   en;
  logic           in_take;

  always_comb begin
    en[NST] = !out_stall;
    for (int i = NST - 1; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0] || div_busy;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_take;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  logic [NST-1:0] last_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      last_r[0] <= in_batch_end;
    end
    for (int i = 1; i < NST; i++) begin
      if (en[i]) begin
        last_r[i] <= last_r[i-1];
      end
    end
  end

  // Stage 0: absolute differences, y forced to zero in one-dimensional mode.
  logic [16:0] dx;
  logic [16:0] dy;
  logic [15:0] ux_r;
  logic [15:0] uy_r;

  always_comb begin
    dx = {in_stim_x[15], in_stim_x} - {in_pref_x[15], in_pref_x};
    dy = {in_stim_y[15], in_stim_y} - {in_pref_y[15], in_pref_y};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ux_r <= dx[16] ? 16'(~dx + 17'd1) : dx[15:0];
      uy_r <= one_dim_r ? 16'd0 : (dy[16] ? 16'(~dy + 17'd1) : dy[15:0]);
    end
  end

  // Stage 1: squares.
  logic [31:0] sqx_r;
  logic [31:0] sqy_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sqx_r <= 32'(ux_r) * 32'(ux_r);
      sqy_r <= 32'(uy_r) * 32'(uy_r);
    end
  end

  // Stage 2: squared distance.
  logic [32:0] d2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      d2_r <= 33'(sqx_r) + 33'(sqy_r);
    end
  end

  // Stage 3: partial products of the scaled exponent.
  logic [48:0] pa_r;
  logic [47:0] pb_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pa_r <= 49'(d2_r[32:16]) * 49'(inv_scale);
      pb_r <= 48'(d2_r[15:0]) * 48'(inv_scale);
    end
  end

  // Stage 4: exponent in Q.16 and far cutoff.
  logic [48:0] lo_sum;
  logic [41:0] e_full;
  logic [19:0] e_r;
  logic [SP:4] zero_r;

  always_comb begin
    lo_sum = {25'd0, pa_r[7:0], 16'd0} + {1'b0, pb_r};
    e_full = 42'(pa_r[48:8]) + 42'(lo_sum[48:24]);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      e_r       <= e_full[19:0];
      zero_r[4] <= |e_full[41:20];
    end
  end

  // Stage 5: conversion to base two.
  logic [36:0]  y_prod;
  logic [4:0]   n_r   [SY:SP-1];
  logic [T-1:0] idx_r [SY:SP-2];

  assign y_prod = 37'(e_r) * 37'(gtr_pkg::LOG2E_Q16);

  always_ff @(posedge clk) begin
    if (en[SY]) begin
      n_r[SY]    <= y_prod[36:32];
      idx_r[SY]  <= y_prod[31:32-T];
      zero_r[SY] <= zero_r[4];
    end
  end

  // Stages 6 .. 5+T: one factor of the fractional power per stage.
  logic [30:0] m_r [SY+1:SP-1];

  genvar g;
  generate
    for (g = 0; g < T; g++) begin : g_fact
      localparam int unsigned S = SY + 1 + g;
      logic [30:0] m_in;
      logic [60:0] mp;
      logic [30:0] m_nxt;

      if (g == 0) begin : g_first
        assign m_in = 31'h4000_0000;
      end else begin : g_rest
        assign m_in = m_r[S-1];
      end

      assign mp    = 61'(m_in) * 61'(gtr_pkg::half_pow_factor(g + 1));
      assign m_nxt = idx_r[S-1][T-1-g] ? mp[60:30] : m_in;

      always_ff @(posedge clk) begin
        if (en[S]) begin
          m_r[S]    <= m_nxt;
          n_r[S]    <= n_r[S-1];
          zero_r[S] <= zero_r[S-1];
        end
      end

      if (g < T - 1) begin : g_idx
        always_ff @(posedge clk) begin
          if (en[S]) begin
            idx_r[S] <= idx_r[S-1];
          end
        end
      end
    end
  endgenerate

  // Product with the peak rate.
  logic [46:0] p_r;
  logic [4:0]  np_r;

  always_ff @(posedge clk) begin
    if (en[SP]) begin
      p_r        <= 47'(peak_r) * 47'(m_r[SP-1]);
      np_r       <= n_r[SP-1];
      zero_r[SP] <= zero_r[SP-1];
    end
  end

  // Output stage: rounding shift, saturation and far cutoff to zero.
  logic [62:0] rnd;
  logic [62:0] r_full;
  logic [15:0] rate_r;

  always_comb begin
    rnd    = 63'(p_r) + (63'd1 << (6'd29 + 6'(np_r)));
    r_full = rnd >> (6'd30 + 6'(np_r));
  end

  always_ff @(posedge clk) begin
    if (en[SO]) begin
      if (zero_r[SP]) begin
        rate_r <= 16'd0;
      end else if (|r_full[62:16]) begin
        rate_r <= gtr_pkg::RATE_MAX;
      end else begin
        rate_r <= r_full[15:0];
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_rate  = rate_r;
  assign out_last  = last_r[NST-1];

  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> in_stall)
    else $error("item accepted while the scale is being derived");

  a_take_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> v_r[0])
    else $error("accepted item did not enter the first stage");

  a_div_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(div_busy) |-> $past(wr_en && (wr_idx == gtr_pkg::REG_SIGMA)))
    else $error("scale derivation started without a sigma write");

endmodule
